FILE: hw/rtl/mts_pkg.sv
// mts_pkg: shared types and constants of the markup token scanner
// transaction payload structs, token kind codes, character codes, scan phases
// depends on nothing; imported by markup_token_scanner and the testbench
package mts_pkg;

  localparam int POS_BITS = 16;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  // token kinds
  localparam logic [3:0] K_END     = 4'd0;
  localparam logic [3:0] K_HEAD    = 4'd1;
  localparam logic [3:0] K_COPEN   = 4'd2;
  localparam logic [3:0] K_CCLOSE  = 4'd3;
  localparam logic [3:0] K_AOPEN   = 4'd4;
  localparam logic [3:0] K_ACLOSE  = 4'd5;
  localparam logic [3:0] K_COMMENT = 4'd6;
  localparam logic [3:0] K_META    = 4'd7;
  localparam logic [3:0] K_TEXT    = 4'd8;

  // character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_TEXT  = 8'b0000_0010,
    PH_LBRK  = 8'b0000_0100,
    PH_RBRK  = 8'b0000_1000,
    PH_AT    = 8'b0001_0000,
    PH_PCT   = 8'b0010_0000,
    PH_DASH1 = 8'b0100_0000,
    PH_DASH2 = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] text_start;
    logic [15:0] text_length;
    logic        last_of_run;
  } out_item_t;

endpackage

FILE: hw/rtl/markup_token_scanner.sv
// markup_token_scanner: character stream in, token transactions out
// scan state update plus a small result queue in one module
// depends on mts_pkg
//
//  channel | dir | payload    | handshake
//  --------+-----+------------+------------------------
//  in_     | in  | in_item_t  | in_valid / in_ready
//  out_    | out | out_item_t | out_valid / out_ready
//
// one character transaction is taken per cycle while the result queue has room
// for two entries; results leave one per cycle while out_ready is high, so a
// character that yields two tokens (lone close bracket before a heading, or end
// of document with a pending token) drains them in turn through the single output port.
// results are written into the registered queue; out_valid comes from its fill count.
// synchronous active-low reset clears scan state and the queue, no clearing pass.
// in_ready depends only on the queue fill, never combinationally on out_ready.
module markup_token_scanner
  import mts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // scan state
  phase_t phase_r, phase_nxt;
  pos_t   pos_r, pos_nxt;
  pos_t   tb_r, tb_nxt;

  // result queue
  out_item_t           q_r [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]     cnt_r, cnt_nxt;

  logic      in_fire;
  logic      out_fire;
  logic [1:0] n_res;
  out_item_t r0, r1;

  // token start decode
  logic      ws;
  phase_t    start_ph;
  logic      start_set;
  logic      start_head;
  pos_t      len;
  out_item_t text_res;
  out_item_t simple_res;
  logic [7:0] c;

  assign c        = in_data.ch;
  assign in_ready = (cnt_r <= Q_CW'(Q_DEPTH - 2));
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = q_r[rd_ptr_r];

  // c-locale whitespace: space, tab through carriage return
  assign ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  assign len = (pos_r >= tb_r) ? (pos_r - tb_r) : '0;

  always_comb begin
    text_res             = '0;
    text_res.kind        = K_TEXT;
    text_res.text_start  = 16'(tb_r);
    text_res.text_length = 16'(len);
    simple_res           = '0;
  end

  always_comb begin
    start_set  = !ws;
    start_head = 1'b0;
    start_ph   = PH_IDLE;
    if (!ws) begin
      unique case (c)
        CH_HASH: start_head = 1'b1;
        CH_LBRK: start_ph = PH_LBRK;
        CH_RBRK: start_ph = PH_RBRK;
        CH_AT:   start_ph = PH_AT;
        CH_PCT:  start_ph = PH_PCT;
        CH_DASH: start_ph = PH_DASH1;
        default: start_ph = PH_TEXT;
      endcase
    end
  end

  // next state and up to two results for the incoming character
  always_comb begin
    phase_nxt = phase_r;
    tb_nxt    = tb_r;
    pos_nxt   = pos_r;
    n_res     = 2'd0;
    r0        = simple_res;
    r1        = simple_res;

    if (in_data.is_end) begin
      // flush pending prefix or text, then end of document
      phase_nxt = PH_IDLE;
      pos_nxt   = '0;
      tb_nxt    = '0;
      r1.kind   = K_END;
      unique case (phase_r)
        PH_IDLE: begin
          r0.kind = K_END;
          n_res   = 2'd1;
        end
        PH_RBRK: begin
          r0.kind = K_ACLOSE;
          n_res   = 2'd2;
        end
        default: begin
          r0    = text_res;
          n_res = 2'd2;
        end
      endcase
    end else begin
      pos_nxt = (pos_r != POS_MAX) ? pos_r + pos_t'(1) : pos_r;
      unique case (phase_r)
        PH_RBRK: begin
          if (c == CH_RBRK) begin
            r0.kind   = K_CCLOSE;
            n_res     = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            // lone close bracket, then rescan this character as a token start
            r0.kind   = K_ACLOSE;
            n_res     = 2'd1;
            phase_nxt = start_ph;
            if (start_set) begin
              tb_nxt = pos_r;
            end
            if (start_head) begin
              r1.kind = K_HEAD;
              n_res   = 2'd2;
            end
          end
        end
        PH_TEXT, PH_LBRK, PH_AT, PH_PCT, PH_DASH1, PH_DASH2: begin
          if ((phase_r == PH_LBRK) && (c == CH_LBRK)) begin
            r0.kind   = K_COPEN;
            n_res     = 2'd1;
            phase_nxt = PH_IDLE;
          end else if ((phase_r == PH_AT) && (c == CH_LBRK)) begin
            r0.kind   = K_AOPEN;
            n_res     = 2'd1;
            phase_nxt = PH_IDLE;
          end else if ((phase_r == PH_PCT) && (c == CH_PCT)) begin
            r0.kind   = K_COMMENT;
            n_res     = 2'd1;
            phase_nxt = PH_IDLE;
          end else if ((phase_r == PH_DASH1) && (c == CH_DASH)) begin
            phase_nxt = PH_DASH2;
          end else if ((phase_r == PH_DASH2) && (c == CH_DASH)) begin
            r0.kind   = K_META;
            n_res     = 2'd1;
            phase_nxt = PH_IDLE;
          end else if (ws) begin
            // prefix or text ends at whitespace
            r0        = text_res;
            n_res     = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TEXT;
          end
        end
        default: begin
          // idle between tokens
          phase_nxt = start_ph;
          if (start_set) begin
            tb_nxt = pos_r;
          end
          if (start_head) begin
            r0.kind = K_HEAD;
            n_res   = 2'd1;
          end
        end
      endcase
    end

    // mark the final result of this character
    if (n_res == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last_of_run = 1'b1;
    end
  end

  // queue pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + Q_AW'(n_res);
      cnt_nxt    = cnt_nxt + Q_CW'(n_res);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + Q_AW'(1);
      cnt_nxt    = cnt_nxt - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      tb_r     <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        tb_r    <= tb_nxt;
      end
    end
  end

  // result entries carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_res != 2'd0) begin
        q_r[wr_ptr_r] <= r0;
      end
      if (n_res == 2'd2) begin
        q_r[wr_ptr_r + Q_AW'(1)] <= r1;
      end
    end
  end

  // fill count never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("result queue overfilled");

  // fill count agrees with the pointer distance
  a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[Q_AW-1:0] == Q_AW'(wr_ptr_r - rd_ptr_r))
    else $error("queue count and pointers disagree");

  // end of document returns the scanner to its reset state
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.is_end) |=> (phase_r == PH_IDLE) && (pos_r == '0) && (tb_r == '0))
    else $error("scan state not cleared after end of document");

  // only text tokens carry a position and length
  a_nontext_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind != K_TEXT)) |->
      (out_data.text_start == 16'd0) && (out_data.text_length == 16'd0))
    else $error("non-text token carries position data");

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for the markup token scanner
// drives character transactions, predicts every token and checks the result channel
// depends on mts_pkg and markup_token_scanner
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  // bench knobs
  localparam int MAX_IDLE     = 7;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_SHOWN    = 10;
  localparam int LIMIT_NS     = 1_000_000;

  // plain bytes used by the directed cases
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TOP   = 8'hff;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // idling switches, shared by the sender, the sink and the tests
  bit send_idle = 1'b1;
  bit sink_idle = 1'b1;
  // request for one long receiver hold-off, cleared by the sink when done
  bit hold_req  = 1'b0;

  int mismatch_count = 0;
  int items_sent     = 0;

  // scanner state as the predictor sees it
  phase_t scan_ph  = PH_IDLE;
  pos_t   char_pos = '0;
  pos_t   tok_pos  = '0;

  // tokens caused by the current character, then all tokens still due
  out_item_t step_tokens[$];
  out_item_t expected_tokens[$];

  markup_token_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // token predictor
  // ---------------------------------------------------------------------------

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic out_item_t make_token(logic [3:0] kind, pos_t start, pos_t len);
    out_item_t t;
    t.kind        = kind;
    t.text_start  = 16'(start);
    t.text_length = 16'(len);
    t.last_of_run = 1'b0;
    return t;
  endfunction

  // text token from the pending start up to the current position
  function automatic void emit_text();
    step_tokens.push_back(make_token(K_TEXT, tok_pos,
                                     (char_pos >= tok_pos) ? pos_t'(char_pos - tok_pos) : '0));
  endfunction

  // recognized lexeme, scanner goes back to idle
  function automatic void close_token(logic [3:0] kind);
    step_tokens.push_back(make_token(kind, '0, '0));
    scan_ph = PH_IDLE;
  endfunction

  // c seen as the first character of a new token
  function automatic void begin_token(logic [7:0] c);
    scan_ph = PH_IDLE;
    if (!is_blank(c)) begin
      tok_pos = char_pos;
      case (c)
        CH_HASH: step_tokens.push_back(make_token(K_HEAD, '0, '0));
        CH_LBRK: scan_ph = PH_LBRK;
        CH_RBRK: scan_ph = PH_RBRK;
        CH_AT:   scan_ph = PH_AT;
        CH_PCT:  scan_ph = PH_PCT;
        CH_DASH: scan_ph = PH_DASH1;
        default: scan_ph = PH_TEXT;
      endcase
    end
  endfunction

  // pending prefix became text: blank ends it, anything else extends it
  function automatic void extend_text(logic [7:0] c);
    if (is_blank(c)) begin
      emit_text();
      scan_ph = PH_IDLE;
    end else begin
      scan_ph = PH_TEXT;
    end
  endfunction

  // one accepted character or end transaction: queue the tokens it causes
  function automatic void predict_tokens(in_item_t it);
    out_item_t tok;
    step_tokens.delete();
    if (it.is_end) begin
      // flush what is pending, then end of document and back to reset state
      case (scan_ph)
        PH_IDLE: ;
        PH_RBRK: step_tokens.push_back(make_token(K_ACLOSE, '0, '0));
        default: emit_text();
      endcase
      step_tokens.push_back(make_token(K_END, '0, '0));
      scan_ph  = PH_IDLE;
      char_pos = '0;
      tok_pos  = '0;
    end else begin
      case (scan_ph)
        PH_IDLE:  begin_token(it.ch);
        PH_TEXT:  extend_text(it.ch);
        PH_LBRK:  if (it.ch == CH_LBRK) close_token(K_COPEN); else extend_text(it.ch);
        PH_RBRK: begin
          // lone close bracket: annotation close, then c starts a new token
          if (it.ch == CH_RBRK) begin
            close_token(K_CCLOSE);
          end else begin
            step_tokens.push_back(make_token(K_ACLOSE, '0, '0));
            begin_token(it.ch);
          end
        end
        PH_AT:    if (it.ch == CH_LBRK) close_token(K_AOPEN); else extend_text(it.ch);
        PH_PCT:   if (it.ch == CH_PCT) close_token(K_COMMENT); else extend_text(it.ch);
        PH_DASH1: if (it.ch == CH_DASH) scan_ph = PH_DASH2; else extend_text(it.ch);
        PH_DASH2: if (it.ch == CH_DASH) close_token(K_META); else extend_text(it.ch);
        default:  ;
      endcase
      // position saturates at its bound
      if (char_pos != POS_MAX) char_pos = char_pos + 1'b1;
    end
    foreach (step_tokens[i]) begin
      tok = step_tokens[i];
      tok.last_of_run = (i == step_tokens.size() - 1);
      expected_tokens.push_back(tok);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one input transaction; returns right after the edge that accepted it,
  // so a following call in the same step keeps valid high without a dip
  task automatic send_item(input logic [7:0] c, input logic e);
    int       gap;
    bit       took;
    in_item_t it;
    it.ch     = c;
    it.is_end = e;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // in_ready is registered, so its mid-cycle value is the one seen at the edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    predict_tokens(it);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  // end of document; the character byte is don't-care, so it is random
  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // drop valid before anything that lets time pass without sending
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // character sequence of one recognized token kind
  task automatic send_lexeme(input logic [3:0] kind);
    case (kind)
      K_HEAD:    send_char(CH_HASH);
      K_COPEN:   begin send_char(CH_LBRK); send_char(CH_LBRK); end
      K_CCLOSE:  begin send_char(CH_RBRK); send_char(CH_RBRK); end
      K_AOPEN:   begin send_char(CH_AT);   send_char(CH_LBRK); end
      K_ACLOSE:  send_char(CH_RBRK);
      K_COMMENT: begin send_char(CH_PCT);  send_char(CH_PCT);  end
      K_META:    begin send_char(CH_DASH); send_char(CH_DASH); send_char(CH_DASH); end
      default:   ;
    endcase
  endtask

  function automatic logic [7:0] random_solid_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] random_blank();
    if ($urandom_range(0, 1) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // mostly well-formed pieces with random content, some broken prefixes and noise
  task automatic send_random_document(input int pieces);
    int len;
    for (int i = 0; i < pieces; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_lexeme(4'($urandom_range(K_HEAD, K_META)));
        5, 6: begin
          len = $urandom_range(1, 6);
          repeat (len) send_char(random_solid_byte());
        end
        7: begin
          // prefix that the next byte may or may not complete
          case ($urandom_range(0, 4))
            0: send_char(CH_LBRK);
            1: send_char(CH_AT);
            2: send_char(CH_PCT);
            3: send_char(CH_DASH);
            default: begin send_char(CH_DASH); send_char(CH_DASH); end
          endcase
          send_char(8'($urandom_range(0, 255)));
        end
        default: send_char(8'($urandom_range(0, 255)));
      endcase
      // separator most of the time, none now and then so tokens abut
      if ($urandom_range(0, 3) != 0) send_char(random_blank());
    end
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // out_ready owner: random per-result stalls plus one long hold-off on request
  initial begin : result_sink
    int stall;
    bit took;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    if (mismatch_count < MAX_SHOWN) begin
      $display("%0t %s: expected kind %0d start %0d len %0d last %0b,",
               $realtime, what, want.kind, want.text_start, want.text_length, want.last_of_run);
      $display("  got kind %0d start %0d len %0d last %0b",
               got.kind, got.text_start, got.text_length, got.last_of_run);
    end
    mismatch_count++;
  endfunction

  // both handshake signals are stable mid-cycle: check what the next edge takes
  always @(negedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_tokens.size() == 0) begin
        note_mismatch("unexpected token", '0, out_data);
      end else begin
        want = expected_tokens.pop_front();
        if (out_data !== want) note_mismatch("token mismatch", want, out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every kind at least once, adjacent tokens, unfinished prefixes, zero and top bytes
  task automatic test_token_kinds();
    send_lexeme(K_HEAD);
    send_lexeme(K_COPEN);
    send_lexeme(K_CCLOSE);
    send_lexeme(K_AOPEN);
    // lone close bracket followed directly by a comment
    send_lexeme(K_ACLOSE);
    send_lexeme(K_COMMENT);
    send_lexeme(K_META);
    // lone close bracket then heading: two tokens from one character
    send_lexeme(K_ACLOSE);
    send_lexeme(K_HEAD);
    // open bracket that turns into text, zero byte inside, tab ends it
    send_char(CH_LBRK);
    send_char(CH_NUL);
    send_char(CH_TAB);
    // double dash broken by the top byte
    send_char(CH_DASH);
    send_char(CH_DASH);
    send_char(CH_TOP);
    send_char(CH_SPACE);
    // pending at-sign flushed by the end of document
    send_char(CH_AT);
    send_end();
  endtask

  // pending close bracket at the end, then an empty document
  task automatic test_open_prefix_at_end();
    send_char(CH_RBRK);
    send_end();
    send_end();
  endtask

  // receiver holds off while two-token characters keep coming
  task automatic test_output_stall();
    send_idle = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 1'b1;
    repeat (20) begin
      send_lexeme(K_ACLOSE);
      send_lexeme(K_HEAD);
    end
    send_end();
    send_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // random documents; idling switched per document so some run without gaps
  task automatic test_random_documents();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      send_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      send_random_document($urandom_range(2, 30));
    end
    send_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_token_kinds();
    test_open_prefix_at_end();
    test_output_stall();
    test_random_documents();

    // let every due token come out, then keep watching for stray tokens
    stop_sending();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
